// ----- rtl/rgd_pkg.sv -----
// ---------------------------------------------------------------------------
// rgd_pkg
// Shared constants, opcodes and memory request types of the raster drawer.
// ---------------------------------------------------------------------------
`default_nettype none
package rgd_pkg;

	localparam int FRAME_COLS = 128;
	localparam int FRAME_ROWS = 64;
	localparam int STRIP_BITS = 16384;

	localparam int FADDR_W = $clog2(FRAME_COLS * FRAME_ROWS);
	localparam int SADDR_W = $clog2(STRIP_BITS);
	localparam int SIDX_W  = 17;

	localparam logic [2:0] OP_COLOUR = 3'd0;
	localparam logic [2:0] OP_MOVE   = 3'd1;
	localparam logic [2:0] OP_PIXEL  = 3'd2;
	localparam logic [2:0] OP_RECT   = 3'd3;
	localparam logic [2:0] OP_GLYPH  = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;
	localparam logic [2:0] OP_LOAD   = 3'd6;

	localparam logic [2:0] REG_ACT_W   = 3'd0;
	localparam logic [2:0] REG_ACT_H   = 3'd1;
	localparam logic [2:0] REG_FIRST   = 3'd2;
	localparam logic [2:0] REG_LAST    = 3'd3;
	localparam logic [2:0] REG_GLYPH_W = 3'd4;
	localparam logic [2:0] REG_GLYPH_H = 3'd5;
	localparam logic [2:0] REG_PITCH   = 3'd6;
	localparam logic [2:0] REG_BASE    = 3'd7;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [FADDR_W-1:0] addr;
		logic [15:0]        wdata;
	} frame_req_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [SADDR_W-1:0] addr;
		logic               wdata;
	} strip_req_t;

	function automatic logic [FADDR_W-1:0] frame_addr(logic [10:0] col, logic [10:0] row);
		frame_addr = FADDR_W'(row) * FADDR_W'(FRAME_COLS) + FADDR_W'(col);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rgd_if.sv -----
// ---------------------------------------------------------------------------
// rgd_if
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface rgd_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [23:0] rgb;
	logic [9:0]  x_pos;
	logic [9:0]  y_pos;
	logic [9:0]  rect_width;
	logic [9:0]  rect_height;
	logic [7:0]  char_code;
	logic [3:0]  scale;
	logic [13:0] glyph_bit_index;
	logic        glyph_bit;

	modport source (output valid, operation, rgb, x_pos, y_pos, rect_width, rect_height,
		char_code, scale, glyph_bit_index, glyph_bit, input ready);
	modport sink (input valid, operation, rgb, x_pos, y_pos, rect_width, rect_height,
		char_code, scale, glyph_bit_index, glyph_bit, output ready);
endinterface

interface rgd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic [9:0]  cursor_col;
	logic [9:0]  cursor_row;
	logic        char_skipped;

	modport source (output valid, read_data, cursor_col, cursor_row, char_skipped,
		input ready);
	modport sink (input valid, read_data, cursor_col, cursor_row, char_skipped,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/rgd_frame_mem.sv -----
// ---------------------------------------------------------------------------
// rgd_frame_mem
// RGB565 frame store, one port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module rgd_frame_mem
	import rgd_pkg::*;
(
	input  wire logic       clk,
	input  wire frame_req_t req,
	output logic [15:0]     rdata
);
	logic [15:0] mem [FRAME_COLS*FRAME_ROWS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rgd_strip_mem.sv -----
// ---------------------------------------------------------------------------
// rgd_strip_mem
// One-bit glyph strip store, one port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module rgd_strip_mem
	import rgd_pkg::*;
(
	input  wire logic       clk,
	input  wire strip_req_t req,
	output logic            rdata
);
	logic mem [STRIP_BITS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rgd_seq.sv -----
// ---------------------------------------------------------------------------
// rgd_seq
// Operation sequencer: registers, pixel walk and memory requests.
// ---------------------------------------------------------------------------
`default_nettype none
module rgd_seq
	import rgd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	rgd_in_if.sink           in_ch,
	rgd_out_if.source        out_ch,
	output frame_req_t       frame_req,
	input  wire logic [15:0] frame_rdata,
	output strip_req_t       strip_req,
	input  wire logic        strip_rdata
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RECT  = 2'd1;
	localparam logic [1:0] ST_GLYPH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]  state_q;
	logic [7:0]  act_w_q;
	logic [6:0]  act_h_q;
	logic [7:0]  first_q;
	logic [7:0]  last_q;
	logic [3:0]  gw_q;
	logic [4:0]  gh_q;
	logic [10:0] pitch_q;
	logic [3:0]  base_q;
	logic [15:0] pen_q;
	logic [9:0]  cx_q;
	logic [9:0]  cy_q;

	logic [10:0]        x0_q;
	logic [10:0]        col_q;
	logic signed [11:0] row_q;
	logic [10:0]        xend_q;
	logic [10:0]        yend_q;
	logic [4:0]         j_q;
	logic [3:0]         s_q;
	logic [3:0]         ci_q;
	logic [3:0]         si_q;
	logic [3:0]         scale_q;
	logic [SIDX_W-1:0]  rb_q;
	logic               skip_q;
	logic               rd_ok_q;

	logic               v_s1;
	logic               ink_s1;
	logic [FADDR_W-1:0] faddr_s1;

	logic        ov_q;
	logic [15:0] o_data_q;
	logic [9:0]  o_col_q;
	logic [9:0]  o_row_q;
	logic        o_skip_q;

	logic               accept;
	logic [10:0]        wlim, hlim;
	logic [10:0]        xsum, ysum, xend, yend;
	logic               code_ok, gvoid;
	logic [11:0]        gbase;
	logic [7:0]         gdrop;
	logic [7:0]         gadv;
	logic [10:0]        adv;
	logic signed [11:0] gtop;
	logic               pix_ok, rd_ok;
	logic [SIDX_W-1:0]  sidx;
	logic               sidx_ok, cell_ok;
	logic               last_i, last_s;
	logic               v_nxt;
	logic               ov_set;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign wlim = ({3'b0, act_w_q} < 11'(FRAME_COLS)) ? {3'b0, act_w_q} : 11'(FRAME_COLS);
	assign hlim = ({4'b0, act_h_q} < 11'(FRAME_ROWS)) ? {4'b0, act_h_q} : 11'(FRAME_ROWS);

	assign xsum = {1'b0, cx_q} + {1'b0, in_ch.rect_width};
	assign ysum = {1'b0, cy_q} + {1'b0, in_ch.rect_height};
	assign xend = (xsum < wlim) ? xsum : wlim;
	assign yend = (ysum < hlim) ? ysum : hlim;

	assign code_ok = (in_ch.char_code >= first_q) && (in_ch.char_code <= last_q);
	assign gvoid   = (gh_q == 5'd0) || (gw_q == 4'd0) || (in_ch.scale == 4'd0);
	assign gbase   = 12'(in_ch.char_code - first_q) * 12'(gw_q);
	assign gdrop   = 8'(base_q) * 8'(in_ch.scale);
	assign gadv    = 8'(gw_q) * 8'(in_ch.scale);
	assign gtop    = $signed({2'b0, cy_q}) - $signed({4'b0, gdrop});
	assign adv     = ({1'b0, cx_q} + {3'b0, gadv} > 11'd1023) ? 11'd1023
	                 : {1'b0, cx_q} + {3'b0, gadv};

	assign pix_ok = ({1'b0, cx_q} < wlim) && ({1'b0, cy_q} < hlim);
	assign rd_ok  = ({1'b0, in_ch.x_pos} < wlim) && ({1'b0, in_ch.y_pos} < hlim);

	assign sidx    = rb_q + SIDX_W'(ci_q);
	assign sidx_ok = sidx < SIDX_W'(STRIP_BITS);
	assign cell_ok = sidx_ok && !row_q[11] && (col_q < wlim) && (11'(row_q) < hlim);
	assign last_i  = (ci_q + 4'd1 == gw_q) && (si_q + 4'd1 == scale_q);
	assign last_s  = (s_q + 4'd1 == scale_q);

	// a finished result moves to the output register once the old one is gone
	assign ov_set = (state_q == ST_DONE) && (!ov_q || out_ch.ready);

	always_comb begin
		unique case (state_q)
			ST_IDLE:  v_nxt = accept && (in_ch.operation == OP_PIXEL) && pix_ok;
			ST_RECT:  v_nxt = 1'b1;
			ST_GLYPH: v_nxt = cell_ok;
			default:  v_nxt = 1'b0;
		endcase
	end

	always_comb begin
		frame_req.we    = v_s1 && (!ink_s1 || strip_rdata);
		frame_req.re    = accept && (in_ch.operation == OP_READ) && rd_ok;
		frame_req.addr  = v_s1 ? faddr_s1
		                  : frame_addr({1'b0, in_ch.x_pos}, {1'b0, in_ch.y_pos});
		frame_req.wdata = pen_q;
		strip_req.we    = accept && (in_ch.operation == OP_LOAD)
		                  && (SIDX_W'(in_ch.glyph_bit_index) < SIDX_W'(STRIP_BITS));
		strip_req.re    = (state_q == ST_GLYPH) && sidx_ok;
		strip_req.addr  = strip_req.we ? SADDR_W'(in_ch.glyph_bit_index) : SADDR_W'(sidx);
		strip_req.wdata = in_ch.glyph_bit;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_w_q <= 8'd128;
			act_h_q <= 7'd64;
			first_q <= 8'd32;
			last_q  <= 8'd126;
			gw_q    <= 4'd6;
			gh_q    <= 5'd13;
			pitch_q <= 11'd1024;
			base_q  <= 4'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACT_W:   act_w_q <= cfg_data[7:0];
				REG_ACT_H:   act_h_q <= cfg_data[6:0];
				REG_FIRST:   first_q <= cfg_data[7:0];
				REG_LAST:    last_q  <= cfg_data[7:0];
				REG_GLYPH_W: gw_q    <= cfg_data[3:0];
				REG_GLYPH_H: gh_q    <= cfg_data[4:0];
				REG_PITCH:   pitch_q <= cfg_data;
				REG_BASE:    base_q  <= cfg_data[3:0];
				default:     ;
			endcase
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pen_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			v_s1    <= 1'b0;
			ov_q    <= 1'b0;
			skip_q  <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			v_s1 <= v_nxt;
			if (ov_set) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						skip_q  <= (in_ch.operation == OP_GLYPH) && !code_ok;
						rd_ok_q <= (in_ch.operation == OP_READ) && rd_ok;
						unique case (in_ch.operation)
							OP_COLOUR: begin
								pen_q   <= {in_ch.rgb[23:19], in_ch.rgb[15:10],
									in_ch.rgb[7:3]};
								state_q <= ST_DONE;
							end
							OP_MOVE: begin
								cx_q    <= in_ch.x_pos;
								cy_q    <= in_ch.y_pos;
								state_q <= ST_DONE;
							end
							OP_RECT: begin
								state_q <= (({1'b0, cx_q} < xend) && ({1'b0, cy_q} < yend))
									? ST_RECT : ST_DONE;
							end
							OP_GLYPH: begin
								if (code_ok) begin
									cx_q <= adv[9:0];
								end
								state_q <= (code_ok && !gvoid) ? ST_GLYPH : ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RECT: begin
					if (col_q + 11'd1 >= xend_q && 11'(row_q) + 11'd1 >= yend_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_GLYPH: begin
					if (last_i && last_s && (j_q + 5'd1 == gh_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ov_set) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk counters, pixel stage and result payload
	always_ff @(posedge clk) begin
		ink_s1   <= (state_q == ST_GLYPH);
		faddr_s1 <= (state_q == ST_IDLE) ? frame_addr({1'b0, cx_q}, {1'b0, cy_q})
		            : frame_addr(col_q, 11'(row_q));
		if (accept) begin
			x0_q    <= {1'b0, cx_q};
			col_q   <= {1'b0, cx_q};
			xend_q  <= xend;
			yend_q  <= yend;
			scale_q <= in_ch.scale;
			j_q     <= '0;
			s_q     <= '0;
			ci_q    <= '0;
			si_q    <= '0;
			rb_q    <= SIDX_W'(gbase);
			row_q   <= (in_ch.operation == OP_GLYPH) ? gtop : $signed({2'b0, cy_q});
		end else if (state_q == ST_RECT) begin
			if (col_q + 11'd1 < xend_q) begin
				col_q <= col_q + 11'd1;
			end else begin
				col_q <= x0_q;
				row_q <= row_q + 12'sd1;
			end
		end else if (state_q == ST_GLYPH) begin
			// advance sub-column, then glyph column, then sub-row, then glyph row
			if (last_i) begin
				col_q <= x0_q;
				ci_q  <= '0;
				si_q  <= '0;
				row_q <= row_q + 12'sd1;
				if (last_s) begin
					s_q  <= '0;
					j_q  <= j_q + 5'd1;
					rb_q <= rb_q + SIDX_W'(pitch_q);
				end else begin
					s_q <= s_q + 4'd1;
				end
			end else begin
				col_q <= col_q + 11'd1;
				if (si_q + 4'd1 == scale_q) begin
					si_q <= '0;
					ci_q <= ci_q + 4'd1;
				end else begin
					si_q <= si_q + 4'd1;
				end
			end
		end
		if (ov_set) begin
			o_data_q <= rd_ok_q ? frame_rdata : 16'd0;
			o_col_q  <= cx_q;
			o_row_q  <= cy_q;
			o_skip_q <= skip_q;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.read_data    = o_data_q;
	assign out_ch.cursor_col   = o_col_q;
	assign out_ch.cursor_row   = o_row_q;
	assign out_ch.char_skipped = o_skip_q;
endmodule
`default_nettype wire

// ----- rtl/raster_rect_and_glyph_drawer.sv -----
// Colour, move, pixel, read, strip load, empty draw: done state, then output register.
// Rectangle: walks the clipped area in the rect state, one pixel per cycle.
// Glyph: walks glyph_height * glyph_width * scale^2 cells, one strip read per cycle.
// Requests are taken only in idle; a result behind a stalled one waits in done state.
// Reset clears cursor, pen and control; config registers take their defaults.
// Frame and strip stores are not cleared.
`default_nettype none
module raster_rect_and_glyph_drawer
	import rgd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	rgd_in_if.sink           in_ch,
	rgd_out_if.source        out_ch
);
	frame_req_t  frame_req;
	strip_req_t  strip_req;
	logic [15:0] frame_rdata;
	logic        strip_rdata;

	rgd_seq u_seq (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_ch, .out_ch,
		.frame_req, .frame_rdata, .strip_req, .strip_rdata
	);

	rgd_frame_mem u_frame (.clk, .req(frame_req), .rdata(frame_rdata));
	rgd_strip_mem u_strip (.clk, .req(strip_req), .rdata(strip_rdata));
endmodule
`default_nettype wire

// ----- rtl/rgd_checker.sv -----
// ---------------------------------------------------------------------------
// rgd_port_checks
// Port-level checks of the raster drawer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module rgd_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        out_skip,
	input wire logic [15:0] out_data
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_skip_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_skip |-> out_data == 16'd0)
		else $error("skipped glyph carries read data");

	// hold the result read data and skip flag while it waits
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data) && $stable(out_skip))
		else $error("result changed while stalled");
endmodule

bind raster_rect_and_glyph_drawer rgd_port_checks u_rgd_port_checks (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_skip(out_ch.char_skipped), .out_data(out_ch.read_data)
);
`default_nettype wire

// ----- tb/sv/rgd_checker.sv -----
// ----------------------------------------------------------------------------
// rgd_checker
// Watches the request and result channels of the raster drawer, keeps its own
// copy of the frame, the glyph strip, pen, cursor and registers, and compares
// every result with the one predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module rgd_checker
	import rgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	rgd_in_if           in_ch,
	rgd_out_if          out_ch,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] read_data;
		logic [9:0]  col;
		logic [9:0]  row;
		logic        skipped;
	} draw_result_t;

	logic [15:0] frame_mem [FRAME_COLS*FRAME_ROWS];
	logic        strip_mem [STRIP_BITS];
	logic [15:0] pen;
	int          cur_x, cur_y;
	int          act_w, act_h, code_lo, code_hi, cell_w, cell_h, pitch, base_rows;
	draw_result_t result_q [$];

	function automatic bit visible(int col, int row);
		return col >= 0 && row >= 0 && col < act_w && col < FRAME_COLS &&
			row < act_h && row < FRAME_ROWS;
	endfunction

	function automatic void plot(int col, int row);
		if (visible(col, row))
			frame_mem[row*FRAME_COLS + col] = pen;
	endfunction

	function automatic bit ink_at(int idx);
		return idx < STRIP_BITS && strip_mem[idx] == 1'b1;
	endfunction

	function automatic logic draw_char(int code, int mag);
		int top, first_bit, adv;
		if (code < code_lo || code > code_hi)
			return 1'b1;
		first_bit = (code - code_lo) * cell_w;
		top = cur_y - base_rows * mag;
		for (int j = 0; j < cell_h; j++)
			for (int s = 0; s < mag; s++)
				for (int i = 0; i < cell_w * mag; i++)
					if (ink_at(j*pitch + first_bit + i/mag))
						plot(cur_x + i, top + j*mag + s);
		adv = cur_x + cell_w * mag;
		cur_x = adv > 1023 ? 1023 : adv;
		return 1'b0;
	endfunction

	function automatic draw_result_t draw_and_report();
		draw_result_t r;
		r.read_data = '0;
		r.skipped   = 1'b0;
		case (in_ch.operation)
			OP_COLOUR: pen = {in_ch.rgb[23:19], in_ch.rgb[15:10], in_ch.rgb[7:3]};
			OP_MOVE: begin
				cur_x = int'(in_ch.x_pos);
				cur_y = int'(in_ch.y_pos);
			end
			OP_PIXEL: plot(cur_x, cur_y);
			OP_RECT: begin
				for (int j = 0; j < int'(in_ch.rect_height); j++) begin
					if (!visible(0, cur_y + j))
						break;
					for (int i = 0; i < int'(in_ch.rect_width); i++) begin
						if (!visible(cur_x + i, cur_y + j))
							break;
						plot(cur_x + i, cur_y + j);
					end
				end
			end
			OP_GLYPH: r.skipped = draw_char(int'(in_ch.char_code), int'(in_ch.scale));
			OP_READ: begin
				if (visible(int'(in_ch.x_pos), int'(in_ch.y_pos)))
					r.read_data = frame_mem[int'(in_ch.y_pos)*FRAME_COLS + int'(in_ch.x_pos)];
			end
			OP_LOAD: strip_mem[in_ch.glyph_bit_index] = in_ch.glyph_bit;
			default: ;
		endcase
		r.col = cur_x[9:0];
		r.row = cur_y[9:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_result_t want;
		if (!arst_n) begin
			pen        = '0;
			cur_x      = 0;
			cur_y      = 0;
			act_w      = 128;
			act_h      = 64;
			code_lo    = 32;
			code_hi    = 126;
			cell_w     = 6;
			cell_h     = 13;
			pitch      = 1024;
			base_rows  = 10;
			result_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACT_W:   act_w     = int'(cfg_data[7:0]);
					REG_ACT_H:   act_h     = int'(cfg_data[6:0]);
					REG_FIRST:   code_lo   = int'(cfg_data[7:0]);
					REG_LAST:    code_hi   = int'(cfg_data[7:0]);
					REG_GLYPH_W: cell_w    = int'(cfg_data[3:0]);
					REG_GLYPH_H: cell_h    = int'(cfg_data[4:0]);
					REG_PITCH:   pitch     = int'(cfg_data[10:0]);
					REG_BASE:    base_rows = int'(cfg_data[3:0]);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result rd=%h col=%0d row=%0d skip=%b", $time,
							out_ch.read_data, out_ch.cursor_col, out_ch.cursor_row,
							out_ch.char_skipped);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (out_ch.read_data !== want.read_data || out_ch.cursor_col !== want.col ||
						out_ch.cursor_row !== want.row || out_ch.char_skipped !== want.skipped) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp rd=%h col=%0d row=%0d skip=%b, got rd=%h col=%0d row=%0d skip=%b",
								$time, want.read_data, want.col, want.row, want.skipped,
								out_ch.read_data, out_ch.cursor_col, out_ch.cursor_row,
								out_ch.char_skipped);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				result_q.push_back(draw_and_report());
			pending <= result_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_raster_rect_and_glyph_drawer.sv -----
// ----------------------------------------------------------------------------
// tb_raster_rect_and_glyph_drawer
// Loads the low part of the glyph strip and fills the frame, then runs directed
// and random drawing requests under several register settings with bursty
// requests and a stalling result side; the checker predicts and compares every
// result. Every font setting keeps its strip reads inside the loaded part.
// ----------------------------------------------------------------------------
module tb_raster_rect_and_glyph_drawer;
	import rgd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOADED_BITS = 256;

	typedef struct {
		logic [2:0]  op;
		logic [23:0] rgb;
		logic [9:0]  x, y, w, h;
		logic [7:0]  code;
		logic [3:0]  scale;
		logic [13:0] bidx;
		logic        ink;
	} draw_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	int          fail_count, pending;
	int          burst_left = 0;
	int          op_count [8];
	int          lo_code = 32, hi_code = 126;

	rgd_in_if  in_ch();
	rgd_out_if out_ch();

	raster_rect_and_glyph_drawer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	rgd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_ch.valid           = 1'b0;
		in_ch.operation       = '0;
		in_ch.rgb             = '0;
		in_ch.x_pos           = '0;
		in_ch.y_pos           = '0;
		in_ch.rect_width      = '0;
		in_ch.rect_height     = '0;
		in_ch.char_code       = '0;
		in_ch.scale           = '0;
		in_ch.glyph_bit_index = '0;
		in_ch.glyph_bit       = '0;
		out_ch.ready          = 1'b0;
	end

	// result side: switch between free flow, random stalls and long holds
	always @(posedge clk) begin
		int mode, hold;
		if (hold > 0) begin
			hold = hold - 1;
		end else begin
			mode = $urandom_range(0, 9);
			hold = $urandom_range(4, 40);
		end
		if (mode < 4)
			out_ch.ready <= 1'b1;
		else if (mode < 8)
			out_ch.ready <= 1'($urandom_range(0, 1));
		else
			out_ch.ready <= (hold == 0);
	end

	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send(draw_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left = burst_left - 1;
		in_ch.valid           <= 1'b1;
		in_ch.operation       <= r.op;
		in_ch.rgb             <= r.rgb;
		in_ch.x_pos           <= r.x;
		in_ch.y_pos           <= r.y;
		in_ch.rect_width      <= r.w;
		in_ch.rect_height     <= r.h;
		in_ch.char_code       <= r.code;
		in_ch.scale           <= r.scale;
		in_ch.glyph_bit_index <= r.bidx;
		in_ch.glyph_bit       <= r.ink;
		// ready only moves at edges: seen high mid-cycle means taken at the next edge
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		op_count[r.op]++;
	endtask

	function automatic draw_req_t blank(logic [2:0] op);
		draw_req_t r;
		r.op    = op;
		r.rgb   = 24'($urandom());
		r.x     = 10'($urandom());
		r.y     = 10'($urandom());
		r.w     = 10'($urandom());
		r.h     = 10'($urandom());
		r.code  = 8'($urandom());
		r.scale = 4'($urandom());
		r.bidx  = 14'($urandom());
		r.ink   = 1'($urandom());
		return r;
	endfunction

	task automatic do_op(logic [2:0] op, int a = 0, int b = 0);
		draw_req_t r;
		r = blank(op);
		case (op)
			OP_COLOUR: r.rgb = 24'(a);
			OP_MOVE, OP_READ: begin
				r.x = 10'(a);
				r.y = 10'(b);
			end
			OP_RECT: begin
				r.w = 10'(a);
				r.h = 10'(b);
			end
			OP_GLYPH: begin
				r.code  = 8'(a);
				r.scale = 4'(b);
			end
			OP_LOAD: begin
				r.bidx = 14'(a);
				r.ink  = 1'(b);
			end
			default: ;
		endcase
		send(r);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 11'(val);
		@(posedge clk);
	endtask

	task automatic set_font(int aw, int ah, int lo, int hi, int gw, int gh, int pit, int bl);
		drain();
		write_reg(REG_ACT_W, aw);
		write_reg(REG_ACT_H, ah);
		write_reg(REG_FIRST, lo);
		write_reg(REG_LAST, hi);
		write_reg(REG_GLYPH_W, gw);
		write_reg(REG_GLYPH_H, gh);
		write_reg(REG_PITCH, pit);
		write_reg(REG_BASE, bl);
		cfg_we <= 1'b0;
		lo_code = lo;
		hi_code = hi;
		@(posedge clk);
	endtask

	task automatic random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			do_op(OP_COLOUR, $urandom());
		else if (pick < 25) begin
			if ($urandom_range(0, 4) != 0)
				do_op(OP_MOVE, $urandom_range(0, 127), $urandom_range(0, 63));
			else
				do_op(OP_MOVE, $urandom_range(0, 1023), $urandom_range(0, 1023));
		end else if (pick < 33)
			do_op(OP_PIXEL);
		else if (pick < 48) begin
			if ($urandom_range(0, 9) != 0)
				do_op(OP_RECT, $urandom_range(0, 12), $urandom_range(0, 12));
			else
				do_op(OP_RECT, $urandom_range(0, 1023), $urandom_range(0, 1023));
		end else if (pick < 72) begin
			pick = $urandom_range(0, 99);
			// keep most glyphs small, the big magnifications are slow
			do_op(OP_GLYPH,
				(pick < 85 && lo_code <= hi_code) ? $urandom_range(lo_code, hi_code)
					: $urandom_range(0, 255),
				pick < 70 ? 1 : (pick < 96 ? $urandom_range(2, 3) : $urandom_range(4, 8)));
		end else if (pick < 90) begin
			if ($urandom_range(0, 4) != 0)
				do_op(OP_READ, $urandom_range(0, 127), $urandom_range(0, 63));
			else
				do_op(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 1023));
		end else if (pick < 98)
			do_op(OP_LOAD, $urandom_range(0, 16383), $urandom_range(0, 1));
		else
			do_op(3'd7);
	endtask

	initial begin
		int texts;
		int gw_r, lo_r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the strip bits that glyphs read and fill the whole frame
		for (int k = 0; k < LOADED_BITS; k++)
			do_op(OP_LOAD, k, $urandom_range(0, 1));
		do_op(OP_COLOUR, $urandom());
		do_op(OP_RECT, FRAME_COLS, FRAME_ROWS);

		// small font: eight codes of 4x8 cells in a 32-bit pitch
		set_font(128, 64, 65, 72, 4, 8, 32, 6);

		// directed: extremes, every operation, clipping and skip cases
		do_op(OP_COLOUR, 24'hffffff);
		do_op(OP_MOVE, 1023, 1023);
		do_op(OP_PIXEL);
		do_op(OP_READ, 1023, 1023);
		do_op(OP_GLYPH, 72, 8);
		do_op(OP_MOVE, 0, 0);
		do_op(OP_GLYPH, 65, 1);
		do_op(OP_GLYPH, 64, 1);
		do_op(OP_GLYPH, 73, 2);
		do_op(OP_GLYPH, 66, 0);
		do_op(OP_COLOUR, 24'h000000);
		do_op(OP_RECT, 0, 5);
		do_op(OP_RECT, 5, 0);
		do_op(OP_MOVE, 120, 60);
		do_op(OP_RECT, 1023, 1023);
		do_op(OP_PIXEL);
		do_op(OP_READ, 127, 63);
		do_op(OP_READ, 128, 0);
		do_op(OP_READ, 0, 64);
		do_op(OP_LOAD, 16383, 1);
		do_op(3'd7);
		do_op(OP_READ, 0, 0);

		// wait for everything to land before going on
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: ;
				1: set_font(1, 1, 0, 15, 8, 16, 1, 0);
				2: set_font(128, 64, 65, 90, 1, 1, 1024, 15);
				3: set_font(0, 0, 200, 100, 15, 31, 2047, 15);
				default: begin
					// size the code range so the last strip read stays in the loaded part
					gw_r = $urandom_range(1, 8);
					lo_r = $urandom_range(0, 60);
					set_font($urandom_range(1, 128), $urandom_range(1, 64), lo_r,
						lo_r + $urandom_range(0, 144 / gw_r - 1), gw_r,
						$urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 15));
				end
			endcase
			for (int n = 0; n < 130; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					// a short line of text with a random start
					do_op(OP_MOVE, $urandom_range(0, 127), $urandom_range(0, 63));
					texts = $urandom_range(1, 4);
					for (int t = 0; t < texts; t++)
						do_op(OP_GLYPH, lo_code <= hi_code ? $urandom_range(lo_code, hi_code)
							: $urandom_range(0, 255), $urandom_range(1, 2));
					n += texts;
				end else begin
					random_op();
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered: colour %0d move %0d pixel %0d rect %0d glyph %0d",
			op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
		$display("         read %0d strip load %0d unused code %0d, five register settings",
			op_count[5], op_count[6], op_count[7]);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
